[src/region_address_translation_table_assert.svh]
// Assertion macros shared by the checker of the region address translation table.
// No dependencies; take in with `include before the checker module.
`ifndef REGION_ADDRESS_TRANSLATION_TABLE_ASSERT_SVH
`define REGION_ADDRESS_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rat_pkg.sv]
// Types and codes of the region address translation table.
// No dependencies; compile first.
package rat_pkg;

  localparam int ADDR_W = 32;
  localparam int SLOT_W = 6;

  // Request actions
  localparam logic [1:0] ACT_ADD          = 2'd0;
  localparam logic [1:0] ACT_REMOVE       = 2'd1;
  localparam logic [1:0] ACT_LIN_TO_PHYS  = 2'd2;
  localparam logic [1:0] ACT_PHYS_TO_LIN  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  // Request held stable for the whole scan and broadcast to every cell
  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] physical_base;
    logic [ADDR_W-1:0] region_size;
    logic [ADDR_W-1:0] region_handle;
  } req_t;

  // Token handed from cell to cell; carries the claim of the first matching cell
  typedef struct packed {
    logic              active;
    logic              done;
    logic [1:0]        status;
    logic [ADDR_W-1:0] value;
    logic [ADDR_W-1:0] offset;
    logic [SLOT_W-1:0] slot;
  } tok_t;

endpackage

[src/region_address_translation_table.sv]
// Region address translation table: top level with request capture, cell chain
// and result stage. Depends on rat_pkg and rat_cell.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+--------------------------
//   request  | in_action, in_address, in_physical_base,| transfer when start && !busy
//            | in_region_size, in_region_handle        |
//   result   | out_status, out_translated,             | out_valid strobe, one cycle,
//            | out_freed_handle, out_slot              | no back-pressure
//
// Timing: a transfer loads the request register and the head token, which walks the row
// of cells one cell per cycle and from the last cell enters the result register.
// busy drops in the strobe cycle, so a new request can transfer at the edge that ends
// it; a request is taken only once the previous one is through.
// Reset (rst_n low, synchronous) frees all entries at once and drops any request
// in flight. The result side cannot stall; the strobe lasts exactly one cycle.
module region_address_translation_table import rat_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_physical_base,
  input  logic [ADDR_W-1:0] in_region_size,
  input  logic [ADDR_W-1:0] in_region_handle,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_translated,
  output logic [ADDR_W-1:0] out_freed_handle,
  output logic [SLOT_W-1:0] out_slot
);

  // Busy from transfer until the token leaves the last cell
  logic busy_r, busy_nxt;

  logic accept;
  assign accept = start && !busy_r;

  // Request held for the whole scan
  req_t req_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.action        <= in_action;
      req_r.address       <= in_address;
      req_r.physical_base <= in_physical_base;
      req_r.region_size   <= in_region_size;
      req_r.region_handle <= in_region_handle;
    end
  end

  // Head token: a zero-size add is settled here and just rides through the chain
  tok_t head_r, head_nxt;
  logic zero_add;

  assign zero_add = (in_action == ACT_ADD) && (in_region_size == '0);

  always_comb begin
    head_nxt = '0;
    if (accept) begin
      head_nxt.active = 1'b1;
      head_nxt.done   = zero_add;
      head_nxt.status = zero_add ? ST_ZERO : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  // Row of cells; the first free or matching cell claims the token
  tok_t tok_chain [0:ENTRIES];
  assign tok_chain[0] = head_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_slot (SLOT_W'(i)),
      .req       (req_r),
      .tok_in    (tok_chain[i]),
      .tok_out   (tok_chain[i+1])
    );
  end

  tok_t tail;
  assign tail = tok_chain[ENTRIES];

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tail.active) begin
      busy_nxt = 1'b0;
    end
  end

  // Result stage: an unclaimed token means a full table for add, a miss otherwise
  logic              hit_ok;
  logic              is_xlate;
  logic [1:0]        status_nxt;
  logic [ADDR_W-1:0] translated_nxt;
  logic [ADDR_W-1:0] freed_nxt;
  logic [SLOT_W-1:0] slot_nxt;

  assign hit_ok   = tail.done && (tail.status == ST_OK);
  assign is_xlate = (req_r.action == ACT_LIN_TO_PHYS) || (req_r.action == ACT_PHYS_TO_LIN);

  always_comb begin
    if (tail.done) begin
      status_nxt = tail.status;
    end else if (req_r.action == ACT_ADD) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_MISS;
    end
    translated_nxt = (hit_ok && is_xlate) ? (tail.value + tail.offset) : '0;
    freed_nxt      = (hit_ok && (req_r.action == ACT_REMOVE)) ? tail.value : '0;
    slot_nxt       = hit_ok ? tail.slot : '0;
  end

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_translated_r;
  logic [ADDR_W-1:0] out_freed_handle_r;
  logic [SLOT_W-1:0] out_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= tail.active;
    end
  end

  // Hold the result payload until the next token arrives
  always_ff @(posedge clk) begin
    if (tail.active) begin
      out_status_r       <= status_nxt;
      out_translated_r   <= translated_nxt;
      out_freed_handle_r <= freed_nxt;
      out_slot_r         <= slot_nxt;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_translated   = out_translated_r;
  assign out_freed_handle = out_freed_handle_r;
  assign out_slot         = out_slot_r;

endmodule

[src/rat_cell.sv]
// One table entry of the region address translation table with its token stage.
// Depends on rat_pkg.
module rat_cell import rat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_slot,
  input  req_t              req,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic [ADDR_W-1:0] lin_r, lin_nxt;
  logic [ADDR_W-1:0] phys_r, phys_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [ADDR_W-1:0] hdl_r, hdl_nxt;
  tok_t              tok_r, tok_nxt;

  logic              occupied;
  logic [ADDR_W-1:0] from_sel;
  logic [ADDR_W-1:0] to_sel;
  logic [ADDR_W:0]   diff;
  logic              in_rng;

  assign occupied = |len_r;
  assign from_sel = (req.action == ACT_PHYS_TO_LIN) ? phys_r : lin_r;
  assign to_sel   = (req.action == ACT_PHYS_TO_LIN) ? lin_r : phys_r;
  // borrow out means the query lies below the base
  assign diff     = {1'b0, req.address} - {1'b0, from_sel};
  assign in_rng   = !diff[ADDR_W] && (diff[ADDR_W-1:0] < len_r);

  always_comb begin
    lin_nxt  = lin_r;
    phys_nxt = phys_r;
    len_nxt  = len_r;
    hdl_nxt  = hdl_r;
    tok_nxt  = tok_in;
    if (tok_in.active && !tok_in.done) begin
      unique case (req.action) inside
        ACT_ADD: begin
          if (!occupied) begin
            lin_nxt       = req.address;
            phys_nxt      = req.physical_base;
            len_nxt       = req.region_size;
            hdl_nxt       = req.region_handle;
            tok_nxt.done  = 1'b1;
            tok_nxt.slot  = cell_slot;
          end
        end
        ACT_REMOVE: begin
          if (occupied && (lin_r == req.address)) begin
            len_nxt       = '0;
            tok_nxt.done  = 1'b1;
            tok_nxt.value = hdl_r;
            tok_nxt.slot  = cell_slot;
          end
        end
        ACT_LIN_TO_PHYS, ACT_PHYS_TO_LIN: begin
          if (occupied && in_rng) begin
            tok_nxt.done   = 1'b1;
            tok_nxt.value  = to_sel;
            tok_nxt.offset = diff[ADDR_W-1:0];
            tok_nxt.slot   = cell_slot;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      len_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lin_r  <= lin_nxt;
    phys_r <= phys_nxt;
    hdl_r  <= hdl_nxt;
  end

  assign tok_out = tok_r;

endmodule

[src/rat_chk.sv]
// Port-level checker of the region address translation table, bound to the top.
// Depends on rat_pkg and region_address_translation_table_assert.svh.
`include "region_address_translation_table_assert.svh"

module rat_chk import rat_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [ADDR_W-1:0] out_translated,
  input logic [ADDR_W-1:0] out_freed_handle,
  input logic [SLOT_W-1:0] out_slot
);

  `RAT_ASSERT_NEXT(a_transfer_busy, clk, rst_n, start && !busy, busy, "busy not raised after transfer")
  `RAT_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy, "result strobe while busy")
  `RAT_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `RAT_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_translated == '0) && (out_freed_handle == '0) && (out_slot == '0), "failed request carries data")
  `RAT_ASSERT_NOW(a_done_result, clk, rst_n, $fell(busy) && $past(rst_n), out_valid, "request finished without result")

endmodule

bind region_address_translation_table rat_chk u_rat_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_translated   (out_translated),
  .out_freed_handle (out_freed_handle),
  .out_slot         (out_slot)
);
